// ===== hw/rtl/srt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_pkg
// types, codes and constants shared by the subscription report table modules
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam logic [31:0] MS_PER_SECOND = 32'd1000;

    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_REMOVE  = 3'd1,
        KIND_RM_SESS = 3'd2,
        KIND_CHECK   = 3'd3,
        KIND_NOTIFY  = 3'd4,
        KIND_CLEAR   = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NO_MATCH = 2'd2
    } status_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DONE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] session;
        logic [31:0] sub_ident;
        logic [7:0]  endpoint_no;
        logic [31:0] cluster_no;
        logic [31:0] attribute_no;
        logic [15:0] floor_seconds;
        logic [15:0] ceiling_seconds;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_ident;
        logic [4:0]  affected_count;
        logic [15:0] due_mask;
        logic [4:0]  active_total;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, clear scan results
        logic rd;       // read slot at scan index
        logic eval;     // evaluate read slot
        logic step;     // advance scan index
        logic finish;   // commit add/remove, build result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;     // scan index at last slot
    } stat_t;

endpackage

// ===== hw/rtl/srt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_ctrl
// sequencer: per item, walk every slot (read, evaluate) then finish
// ----------------------------------------------------------------------------
module srt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output srt_pkg::cmd_t   cmd,
    input  srt_pkg::stat_t  stat
);

    srt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            srt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = srt_pkg::ST_SCAN;
                end
            end
            srt_pkg::ST_SCAN: begin
                cmd.rd     = 1'b1;
                state_next = srt_pkg::ST_EVAL;
            end
            srt_pkg::ST_EVAL: begin
                cmd.eval = 1'b1;
                cmd.step = 1'b1;
                state_next = stat.last ? srt_pkg::ST_DONE : srt_pkg::ST_SCAN;
            end
            srt_pkg::ST_DONE: begin
                cmd.finish = 1'b1;
                state_next = srt_pkg::ST_OUT;
            end
            srt_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = srt_pkg::ST_IDLE;
                end
            end
            default: state_next = srt_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/srt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srt_dp
// slot stores, scan index, per-slot compare and result registers
// ----------------------------------------------------------------------------
module srt_dp #(
    parameter int SLOTS = srt_pkg::SLOTS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  srt_pkg::req_t  req,
    input  srt_pkg::cmd_t  cmd,
    output srt_pkg::stat_t stat,
    output srt_pkg::rsp_t  rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [31:0] MS = srt_pkg::MS_PER_SECOND;

    // payload memories
    logic [15:0] mem_session   [SLOTS];
    logic [31:0] mem_ident     [SLOTS];
    logic [7:0]  mem_endpoint  [SLOTS];
    logic [31:0] mem_cluster   [SLOTS];
    logic [31:0] mem_attribute [SLOTS];
    logic [15:0] mem_floor     [SLOTS];
    logic [15:0] mem_ceiling   [SLOTS];
    logic [31:0] mem_last      [SLOTS];

    logic [SLOTS-1:0] used_reg;
    logic [31:0]      next_ident_reg;
    srt_pkg::req_t    req_reg;
    logic [IW-1:0]    idx_reg;

    // registered read data
    logic [15:0] rd_session_reg;
    logic [31:0] rd_ident_reg, rd_cluster_reg, rd_attribute_reg, rd_last_reg;
    logic [7:0]  rd_endpoint_reg;
    logic [15:0] rd_floor_reg, rd_ceiling_reg;

    // scan results
    logic          free_found_reg, id_found_reg, sess_ok_reg;
    logic [IW-1:0] free_idx_reg, id_idx_reg;
    logic [CW-1:0] affected_reg;
    logic [15:0]   mask_reg;
    srt_pkg::rsp_t rsp_reg;

    assign stat.last = (idx_reg == LAST_IDX);
    assign rsp       = rsp_reg;

    // evaluation of the slot just read
    logic        slot_used;
    logic [31:0] elapsed_ms, limit_ms;
    logic [16:0] limit_s;
    logic        due, path_hit, wipe;

    always_comb begin
        slot_used  = used_reg[idx_reg];
        elapsed_ms = req_reg.now_ms - rd_last_reg;
        path_hit   = (rd_endpoint_reg == req_reg.endpoint_no) &&
                     (rd_cluster_reg == req_reg.cluster_no) &&
                     (rd_attribute_reg == req_reg.attribute_no);
        limit_s    = {1'b0, (req_reg.kind == srt_pkg::KIND_NOTIFY) ? rd_floor_reg
                                                                   : rd_ceiling_reg};
        // floor(e/1000) >= L  <=>  e >= L*1000; 65535*1000 fits in 32 bits
        limit_ms   = 32'(limit_s) * MS;
        due        = slot_used && (elapsed_ms >= limit_ms) &&
                     ((req_reg.kind == srt_pkg::KIND_CHECK) ||
                      (req_reg.kind == srt_pkg::KIND_NOTIFY && path_hit));
        wipe       = slot_used &&
                     ((req_reg.kind == srt_pkg::KIND_CLEAR) ||
                      (req_reg.kind == srt_pkg::KIND_RM_SESS &&
                       rd_session_reg == req_reg.session));
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_session_reg   <= mem_session[idx_reg];
            rd_ident_reg     <= mem_ident[idx_reg];
            rd_endpoint_reg  <= mem_endpoint[idx_reg];
            rd_cluster_reg   <= mem_cluster[idx_reg];
            rd_attribute_reg <= mem_attribute[idx_reg];
            rd_floor_reg     <= mem_floor[idx_reg];
            rd_ceiling_reg   <= mem_ceiling[idx_reg];
            rd_last_reg      <= mem_last[idx_reg];
        end
        if (cmd.eval && due) begin
            mem_last[idx_reg] <= req_reg.now_ms;
        end
        if (cmd.finish && req_reg.kind == srt_pkg::KIND_ADD && free_found_reg) begin
            mem_session[free_idx_reg]   <= req_reg.session;
            mem_ident[free_idx_reg]     <= next_ident_reg;
            mem_endpoint[free_idx_reg]  <= req_reg.endpoint_no;
            mem_cluster[free_idx_reg]   <= req_reg.cluster_no;
            mem_attribute[free_idx_reg] <= req_reg.attribute_no;
            mem_floor[free_idx_reg]     <= req_reg.floor_seconds;
            mem_ceiling[free_idx_reg]   <= req_reg.ceiling_seconds;
            mem_last[free_idx_reg]      <= '0;
        end
        if (cmd.load) begin
            req_reg <= req;
        end
    end

    logic [CW-1:0] active_cnt;
    logic [SLOTS-1:0] used_final;

    always_comb begin
        used_final = used_reg;
        if (req_reg.kind == srt_pkg::KIND_ADD && free_found_reg) begin
            used_final[free_idx_reg] = 1'b1;
        end
        if (req_reg.kind == srt_pkg::KIND_REMOVE && id_found_reg && sess_ok_reg) begin
            used_final[id_idx_reg] = 1'b0;
        end
        active_cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            active_cnt = active_cnt + CW'(used_final[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            next_ident_reg <= 32'd1;
            idx_reg        <= '0;
        end else begin
            if (cmd.load) begin
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
                id_found_reg   <= 1'b0;
                sess_ok_reg    <= 1'b0;
                free_idx_reg   <= '0;
                id_idx_reg     <= '0;
                affected_reg   <= '0;
                mask_reg       <= '0;
            end
            if (cmd.eval) begin
                if (!slot_used && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
                if (slot_used && !id_found_reg && rd_ident_reg == req_reg.sub_ident) begin
                    id_found_reg <= 1'b1;
                    id_idx_reg   <= idx_reg;
                    sess_ok_reg  <= (rd_session_reg == req_reg.session);
                end
                if (wipe) begin
                    used_reg[idx_reg] <= 1'b0;
                end
                if (due || wipe) begin
                    affected_reg <= affected_reg + CW'(1);
                end
                if (due && 32'(idx_reg) < 32'd16) begin
                    mask_reg[4'(idx_reg)] <= 1'b1;
                end
            end
            if (cmd.step && !stat.last) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.finish) begin
                used_reg               <= used_final;
                rsp_reg.status         <= srt_pkg::STAT_OK;
                rsp_reg.new_ident      <= '0;
                rsp_reg.affected_count <= 5'(affected_reg);
                rsp_reg.due_mask       <= mask_reg;
                rsp_reg.active_total   <= 5'(active_cnt);
                if (req_reg.kind == srt_pkg::KIND_ADD) begin
                    rsp_reg.affected_count <= '0;
                    if (free_found_reg) begin
                        rsp_reg.new_ident <= next_ident_reg;
                        next_ident_reg    <= (next_ident_reg == 32'hFFFF_FFFF) ? 32'd1
                                             : next_ident_reg + 32'd1;
                    end else begin
                        rsp_reg.status <= srt_pkg::STAT_FULL;
                    end
                end else if (req_reg.kind == srt_pkg::KIND_REMOVE) begin
                    if (id_found_reg && sess_ok_reg) begin
                        rsp_reg.affected_count <= 5'd1;
                    end else begin
                        rsp_reg.affected_count <= '0;
                        rsp_reg.status         <= srt_pkg::STAT_NO_MATCH;
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/subscription_report_table.sv =====
`timescale 1ns / 1ps
// after the input transfer each slot is read and evaluated in turn, then the result is
//   built and held valid; a new item is taken only once the result is transferred;
//   read and evaluate use the single port of the slot memories in separate states
// reset: synchronous active-low aresetn frees all slots and sets the next id to one;
//   slot payload memories are not cleared
// ----------------------------------------------------------------------------
// subscription_report_table
// table of attribute subscriptions with add, remove, session purge,
// interval check, change notify and clear
// ----------------------------------------------------------------------------
module subscription_report_table #(
    parameter int SLOTS = srt_pkg::SLOTS_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  srt_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output srt_pkg::rsp_t m_data
);

    // command and status between sequencer and datapath
    srt_pkg::cmd_t  cmd;
    srt_pkg::stat_t stat;

    // sequencer: idle, slot walk, finish, hold result until transfer
    srt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // slot stores and result
    srt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .rsp     (m_data)
    );

endmodule
